// File: hw/rtl/mvft_pkg.sv
// Shared types and constants for the marker/value field tokenizer.
package mvft_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ESC_W  = 2;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [ESC_W-1:0] ESCAPE_SPAN = ESC_W'(2);

  localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd59;
  localparam logic [BYTE_W-1:0] ASSIGN_RESET    = 8'd58;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'd92;

  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ASSIGN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARKER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd2;

  typedef enum logic [1:0] {
    MODE_MARKER = 2'd0,
    MODE_VALUE  = 2'd1,
    MODE_ERROR  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] separator_char;
    logic [BYTE_W-1:0] assign_char;
    logic [BYTE_W-1:0] escape_char;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic [ESC_W-1:0] esc_cnt;
  } parse_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              entry_done;
    logic              error_now;
    logic              line_done;
    logic              line_ok;
  } result_t;

endpackage

// File: hw/rtl/mvft_step.sv
// Combinational parse step: one byte against the current state and registers.
module mvft_step (
  input  mvft_pkg::cfg_t              cfg,
  input  mvft_pkg::parse_state_t      state,
  input  logic [mvft_pkg::BYTE_W-1:0] in_byte,
  input  logic                        in_last,
  output mvft_pkg::result_t           result,
  output mvft_pkg::parse_state_t      state_nxt
);
  import mvft_pkg::*;

  logic [ESC_W-1:0] esc_dec;
  logic [ESC_W-1:0] esc_cnt;
  logic             literal;
  logic             is_sep;
  logic             is_assign;
  mode_t            mode;

  always_comb begin
    esc_dec   = (state.esc_cnt != '0) ? state.esc_cnt - ESC_W'(1) : '0;
    esc_cnt   = ((in_byte == cfg.escape_char) && (esc_dec == '0)) ? ESCAPE_SPAN : esc_dec;
    literal   = (esc_cnt != '0);
    is_sep    = (in_byte == cfg.separator_char) && !literal;
    is_assign = (in_byte == cfg.assign_char) && !literal;

    mode              = state.mode;
    result            = '0;
    result.line_done  = in_last;

    unique case (state.mode)
      MODE_MARKER: begin
        if (is_sep) begin
          mode             = MODE_ERROR;
          result.error_now = 1'b1;
        end else if (is_assign) begin
          mode = MODE_VALUE;
        end else begin
          result.data = in_byte;
          result.kind = KIND_MARKER;
        end
      end
      MODE_VALUE: begin
        if (is_assign) begin
          mode             = MODE_ERROR;
          result.error_now = 1'b1;
        end else if (is_sep || in_last) begin
          mode              = MODE_MARKER;
          result.entry_done = 1'b1;
        end else begin
          result.data = in_byte;
          result.kind = KIND_VALUE;
        end
      end
      default: begin
        // Error mode swallows the rest of the line.
        mode    = MODE_ERROR;
        esc_cnt = state.esc_cnt;
      end
    endcase

    result.line_ok = in_last && (mode != MODE_ERROR);

    if (in_last) begin
      state_nxt.mode    = MODE_MARKER;
      state_nxt.esc_cnt = '0;
    end else begin
      state_nxt.mode    = mode;
      state_nxt.esc_cnt = esc_cnt;
    end
  end

endmodule

// File: hw/rtl/marker_value_field_tokenizer.sv
// Top level of the marker/value field tokenizer: registers, handshakes, result register.
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  in_byte, in_last
//  out_     output     out_valid / out_stall out_byte, out_kind, out_entry_done,
//                                           out_error_now, out_line_done, out_line_ok
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per clock unless out_stall holds a full result register: the parse
// step sits between the input ports and the result register, so results are registered.
// Reset (rst_n low, synchronous) returns the registers to their defaults and
// the parser to marker mode. An item is taken whenever the result register is
// empty or being drained in the same cycle; out_stall holds the result.
module marker_value_field_tokenizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mvft_pkg::BYTE_W-1:0]      in_byte,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mvft_pkg::BYTE_W-1:0]      out_byte,
  output logic [mvft_pkg::KIND_W-1:0]      out_kind,
  output logic                             out_entry_done,
  output logic                             out_error_now,
  output logic                             out_line_done,
  output logic                             out_line_ok,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mvft_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mvft_pkg::BYTE_W-1:0]      cfg_data
);
  import mvft_pkg::*;

  cfg_t         cfg_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  result_t      result_nxt;
  result_t      result_r;
  logic         out_valid_r;
  logic         in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator_char <= SEPARATOR_RESET;
      cfg_r.assign_char    <= ASSIGN_RESET;
      cfg_r.escape_char    <= ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEPARATOR: cfg_r.separator_char <= cfg_data;
        REG_ASSIGN:    cfg_r.assign_char    <= cfg_data;
        REG_ESCAPE:    cfg_r.escape_char    <= cfg_data;
        default: ;
      endcase
    end
  end

  mvft_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .result    (result_nxt),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode    <= MODE_MARKER;
      state_r.esc_cnt <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = result_r.data;
  assign out_kind       = result_r.kind;
  assign out_entry_done = result_r.entry_done;
  assign out_error_now  = result_r.error_now;
  assign out_line_done  = result_r.line_done;
  assign out_line_ok    = result_r.line_ok;

  // A line is only reported ok on its last byte.
  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_line_ok |-> out_line_done)
    else $error("line_ok without line_done");

  // A byte that is passed on never closes an entry or raises an error.
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind != KIND_NONE) |-> !out_entry_done && !out_error_now)
    else $error("emitted byte with entry or error flag");

  // The end of a line leaves the parser in its start state.
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last |=> (state_r.mode == MODE_MARKER) && (state_r.esc_cnt == '0))
    else $error("parser not restarted after last byte");

  // Nothing passed on means a zero byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind == KIND_NONE) |-> (out_byte == '0))
    else $error("nonzero byte with no kind");

endmodule
